[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tmcw_pkg.sv]
// ----------------------------------------------------------------------------
// Console writer package
// Operation codes, character codes, cell constants and the prompt table.
// ----------------------------------------------------------------------------
package tmcw_pkg;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_WRITE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0]  RESET_COLOR = 8'h07;
	localparam logic [15:0] RESET_CELL  = {RESET_COLOR, CH_SPACE};

	// prompt emitted on carriage return
	localparam logic [2:0] PROMPT_LAST = 3'd6;

	function automatic logic [7:0] prompt_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h63;
			3'd1: c = 8'h61;
			3'd2: c = 8'h70;
			3'd3: c = 8'h6F;
			3'd4: c = 8'h73;
			3'd5: c = 8'h3E;
			default: c = CH_SPACE;
		endcase
		return c;
	endfunction

	// cursor move flags
	typedef struct packed {
		logic adv_scroll; // plain put wraps off the bottom row
		logic lf_scroll;  // newline leaves the bottom row
		logic bs_move;    // backspace has a cell to erase
	} cur_flags_t;

endpackage

[src/text_mode_console_writer.sv]
// ----------------------------------------------------------------------------
// Text-mode console writer
// Character-cell screen store with cursor, scrolling and prompt output.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                      Contents
// cfg       in   cfg_we, cfg_wdata[7:0]       text colour register write
// s_*       in   s_tvalid/s_tready/s_tdata    command request, op in s_tuser
// m_*       out  m_tvalid/m_tready/m_tdata    cell read back and cursor
//
// Steps: put, null, positioned write, read, newline, backspace: each request is
// accepted, then its result is loaded. Carriage return: 7 prompt writes plus
// a scroll wherever the prompt runs off the bottom. A scroll adds a row copy
// through the single read port of the screen store, a drain step, then the
// last row is blanked one cell a cycle. Clear: one cell written per cycle.
// Reset: a clearing pass fills the store with 0x0720; s_tready stays low
// meanwhile, colour writes are taken as ever.
// Stalls: one output register; a finished result waits in the done state
// only while that register is still full and not being taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_mode_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	localparam int COL_W  = $clog2(COLUMNS),
	localparam int ROW_W  = $clog2(ROWS),
	localparam int IN_BITS  = 16 + COL_W + ROW_W,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 16 + ROW_W + COL_W,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,

	input  logic              s_tvalid,
	output logic              s_tready,
	// char_code[7:0], cell_color[15:8], col, row, zero pad
	input  logic [IN_W-1:0]   s_tdata,
	// op[1:0]
	input  logic [1:0]        s_tuser,

	output logic              m_tvalid,
	input  logic              m_tready,
	// cell_data[15:0], cursor_row, cursor_col, zero pad
	output logic [OUT_W-1:0]  m_tdata
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_A     = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LASTROW_A  = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] ADDR_ONE   = ADDR_W'(1);
	localparam logic [COL_W:0]    COLS_C     = (COL_W + 1)'(COLUMNS);
	localparam logic [ROW_W:0]    ROWS_C     = (ROW_W + 1)'(ROWS);
	localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DONE   = 6'b000010,
		S_PROMPT = 6'b000100,
		S_SCROLL = 6'b001000,
		S_BLANK  = 6'b010000,
		S_CLEAR  = 6'b100000
	} state_t;

	// ------------------------------------------------------------------
	// request fields
	// ------------------------------------------------------------------
	tmcw_pkg::op_t     in_op;
	logic [7:0]        in_char;
	logic [7:0]        in_color;
	logic [COL_W-1:0]  in_col;
	logic [ROW_W-1:0]  in_row;
	logic              in_range;
	logic [ADDR_W-1:0] in_addr;
	logic              s_acc;

	assign in_op    = tmcw_pkg::op_t'(s_tuser);
	assign in_char  = s_tdata[7:0];
	assign in_color = s_tdata[15:8];
	assign in_col   = s_tdata[16 +: COL_W];
	assign in_row   = s_tdata[16 + COL_W +: ROW_W];
	assign in_range = ({1'b0, in_col} < COLS_C) && ({1'b0, in_row} < ROWS_C);
	assign in_addr  = ADDR_W'(in_row) * COLS_A + ADDR_W'(in_col);

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	state_t            state_q, state_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;           // sweep / scroll address
	logic [ROW_W-1:0]  cur_row_q, row_d;
	logic [COL_W-1:0]  cur_col_q, col_d;
	logic [2:0]        prm_idx_q, prm_idx_d;   // prompt character index
	logic              prm_ret_q, prm_ret_d;   // resume prompt after scroll
	logic [15:0]       sweep_cell_q, sweep_cell_d;
	logic              sweep_out_q, sweep_out_d; // clear owes a result
	logic              rd_sel_q, rd_sel_d;     // result takes read data
	logic [7:0]        text_color_q;
	logic              wr_pend_s1, wr_pend_d;  // copy write in flight
	logic [ADDR_W-1:0] wr_addr_s1, wr_addr_d;

	logic              out_valid_q;
	logic [15:0]       out_cell_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic              out_load;

	// screen store ports
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [15:0]       mem_rdata_q;

	logic [15:0]       screen_mem [CELLS];

	logic              scrolling;

	// ------------------------------------------------------------------
	// cursor arithmetic
	// ------------------------------------------------------------------
	logic [ROW_W-1:0]     adv_row, lf_row, bs_row;
	logic [COL_W-1:0]     adv_col, bs_col;
	logic [ADDR_W-1:0]    cur_addr, bs_addr;
	tmcw_pkg::cur_flags_t cflags;

	tmcw_cursor #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_cursor (
		.row      (cur_row_q),
		.col      (cur_col_q),
		.adv_row  (adv_row),
		.adv_col  (adv_col),
		.lf_row   (lf_row),
		.bs_row   (bs_row),
		.bs_col   (bs_col),
		.cur_addr (cur_addr),
		.bs_addr  (bs_addr),
		.flags    (cflags)
	);

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		row_d        = cur_row_q;
		col_d        = cur_col_q;
		prm_idx_d    = prm_idx_q;
		prm_ret_d    = prm_ret_q;
		sweep_cell_d = sweep_cell_q;
		sweep_out_d  = sweep_out_q;
		rd_sel_d     = rd_sel_q;
		wr_pend_d    = 1'b0;
		wr_addr_d    = wr_addr_s1;
		mem_we       = 1'b0;
		mem_waddr    = cur_addr;
		mem_wdata    = {text_color_q, tmcw_pkg::CH_SPACE};
		mem_re       = 1'b0;
		mem_raddr    = cnt_q;
		out_load     = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (s_acc) begin
					rd_sel_d = 1'b0;
					state_d  = S_DONE;
					case (in_op)
						tmcw_pkg::OP_PUT: begin
							case (in_char)
								tmcw_pkg::CH_NUL: begin
									state_d = S_DONE;
								end
								tmcw_pkg::CH_LF: begin
									col_d = '0;
									row_d = lf_row;
									if (cflags.lf_scroll) begin
										prm_ret_d = 1'b0;
										cnt_d     = COLS_A;
										state_d   = S_SCROLL;
									end
								end
								tmcw_pkg::CH_CR: begin
									prm_idx_d = '0;
									state_d   = S_PROMPT;
								end
								tmcw_pkg::CH_BS: begin
									if (cflags.bs_move) begin
										mem_we    = 1'b1;
										mem_waddr = bs_addr;
										row_d     = bs_row;
										col_d     = bs_col;
									end
								end
								default: begin
									mem_we    = 1'b1;
									mem_wdata = {text_color_q, in_char};
									row_d     = adv_row;
									col_d     = adv_col;
									if (cflags.adv_scroll) begin
										prm_ret_d = 1'b0;
										cnt_d     = COLS_A;
										state_d   = S_SCROLL;
									end
								end
							endcase
						end
						tmcw_pkg::OP_WRITE: begin
							mem_we    = in_range;
							mem_waddr = in_addr;
							mem_wdata = {in_color, in_char};
						end
						tmcw_pkg::OP_CLEAR: begin
							sweep_cell_d = {text_color_q, tmcw_pkg::CH_SPACE};
							sweep_out_d  = 1'b1;
							cnt_d        = '0;
							row_d        = '0;
							col_d        = '0;
							state_d      = S_CLEAR;
						end
						default: begin
							mem_re    = in_range;
							mem_raddr = in_addr;
							rd_sel_d  = in_range;
						end
					endcase
				end
			end
			S_PROMPT: begin
				mem_we    = 1'b1;
				mem_wdata = {text_color_q, tmcw_pkg::prompt_char(prm_idx_q)};
				row_d     = adv_row;
				col_d     = adv_col;
				prm_idx_d = prm_idx_q + 3'd1;
				if (cflags.adv_scroll) begin
					prm_ret_d = (prm_idx_q != tmcw_pkg::PROMPT_LAST);
					cnt_d     = COLS_A;
					state_d   = S_SCROLL;
				end else if (prm_idx_q == tmcw_pkg::PROMPT_LAST) begin
					state_d = S_DONE;
				end
			end
			S_SCROLL: begin
				// read the cell one row down, write it back next cycle
				mem_re    = 1'b1;
				mem_raddr = cnt_q;
				wr_pend_d = 1'b1;
				wr_addr_d = cnt_q - COLS_A;
				if (cnt_q == LAST_A) begin
					cnt_d   = LASTROW_A;
					state_d = S_BLANK;
				end else begin
					cnt_d = cnt_q + ADDR_ONE;
				end
			end
			S_BLANK: begin
				// first cycle drains the last copy write
				if (!wr_pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = cnt_q;
					if (cnt_q == LAST_A) begin
						state_d = prm_ret_q ? S_PROMPT : S_DONE;
					end else begin
						cnt_d = cnt_q + ADDR_ONE;
					end
				end
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = sweep_cell_q;
				if (cnt_q == LAST_A) begin
					state_d = sweep_out_q ? S_DONE : S_IDLE;
				end else begin
					cnt_d = cnt_q + ADDR_ONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// scroll copy write takes the port
		if (wr_pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_addr_s1;
			mem_wdata = mem_rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cnt_q        <= '0;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			prm_idx_q    <= '0;
			prm_ret_q    <= 1'b0;
			sweep_cell_q <= tmcw_pkg::RESET_CELL;
			sweep_out_q  <= 1'b0;
			rd_sel_q     <= 1'b0;
			wr_pend_s1   <= 1'b0;
			text_color_q <= tmcw_pkg::RESET_COLOR;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			cur_row_q    <= row_d;
			cur_col_q    <= col_d;
			prm_idx_q    <= prm_idx_d;
			prm_ret_q    <= prm_ret_d;
			sweep_cell_q <= sweep_cell_d;
			sweep_out_q  <= sweep_out_d;
			rd_sel_q     <= rd_sel_d;
			wr_pend_s1   <= wr_pend_d;
			if (cfg_we) begin
				text_color_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		wr_addr_s1 <= wr_addr_d;
		if (out_load) begin
			out_cell_q <= rd_sel_q ? mem_rdata_q : 16'h0000;
			out_row_q  <= cur_row_q;
			out_col_q  <= cur_col_q;
		end
	end

	// screen store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= screen_mem[mem_raddr];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_col_q, out_row_q, out_cell_q});

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	assign scrolling = (state_q == S_SCROLL) || (state_q == S_BLANK);

	`ASSERT_CLK(a_copy_after_scroll, wr_pend_s1 |-> $past(state_q == S_SCROLL), "stray copy write")
	`ASSERT_CLK(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == S_DONE), "early result")
	`ASSERT_CLK(a_scroll_bottom, scrolling |-> cur_row_q == ROW_LAST, "scroll off bottom row")
	`ASSERT_CLK(a_cursor_range, int'(cur_col_q) < COLUMNS && int'(cur_row_q) < ROWS, "bad cursor")
	`ASSERT_RST(a_reset_quiet, !arst_n |-> !m_tvalid && !s_tready, "handshake active in reset")

endmodule

[src/tmcw_cursor.sv]
// ----------------------------------------------------------------------------
// Cursor arithmetic
// Next cursor positions for put, newline and backspace, plus cell addresses.
// ----------------------------------------------------------------------------
module tmcw_cursor #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	localparam int COL_W  = $clog2(COLUMNS),
	localparam int ROW_W  = $clog2(ROWS),
	localparam int ADDR_W = $clog2(ROWS * COLUMNS)
) (
	input  logic [ROW_W-1:0]    row,
	input  logic [COL_W-1:0]    col,
	output logic [ROW_W-1:0]    adv_row,
	output logic [COL_W-1:0]    adv_col,
	output logic [ROW_W-1:0]    lf_row,
	output logic [ROW_W-1:0]    bs_row,
	output logic [COL_W-1:0]    bs_col,
	output logic [ADDR_W-1:0]   cur_addr,
	output logic [ADDR_W-1:0]   bs_addr,
	output tmcw_pkg::cur_flags_t flags
);

	localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  COL_ONE  = COL_W'(1);
	localparam logic [ROW_W-1:0]  ROW_ONE  = ROW_W'(1);
	localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);

	logic at_col_last;
	logic at_row_last;
	logic row_up;

	assign at_col_last = (col == COL_LAST);
	assign at_row_last = (row == ROW_LAST);
	assign row_up      = (row != '0);

	// plain put: advance, wrap to next row, hold on the bottom row (scroll)
	assign adv_col = at_col_last ? '0 : col + COL_ONE;
	assign adv_row = (at_col_last && !at_row_last) ? row + ROW_ONE : row;
	assign lf_row  = at_row_last ? row : row + ROW_ONE;

	always_comb begin
		if (col != '0) begin
			bs_row = row;
			bs_col = col - COL_ONE;
		end else if (row_up) begin
			bs_row = row - ROW_ONE;
			bs_col = COL_LAST;
		end else begin
			bs_row = row;
			bs_col = col;
		end
	end

	assign cur_addr = ADDR_W'(row) * COLS_A + ADDR_W'(col);
	assign bs_addr  = ADDR_W'(bs_row) * COLS_A + ADDR_W'(bs_col);

	assign flags.adv_scroll = at_col_last && at_row_last;
	assign flags.lf_scroll  = at_row_last;
	assign flags.bs_move    = (col != '0) || row_up;

endmodule
